>>> design/spmf_pkg.sv
// spmf_pkg: shared constants, types and helpers for the strict priority multi-level queue
// used by spmf_front, spmf_cmd_q, spmf_back and strict_priority_multi_fifo
package spmf_pkg;

    localparam int LEVELS   = 3;
    localparam int DEPTH    = 16;
    localparam int JOB_BITS = 16;

    // fixed field widths of the request and result ports
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;

    localparam int LVL_W       = $clog2(LEVELS);
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STORE_DEPTH = LEVELS * DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // result queue at the output
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [0:0] {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   addr;
        logic [JOB_BITS-1:0] job;
        logic [LEVEL_W-1:0]  level;
        t_status             status;
    } t_cmd;

    typedef struct packed {
        logic [JOB_BITS-1:0] job;
        logic [LEVEL_W-1:0]  level;
        t_status             status;
    } t_result;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] ptr);
        return ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
    endfunction

endpackage

>>> design/spmf_front.sv
// spmf_front: per-level head, tail and fill bookkeeping; turns a request into a store command
// depends on spmf_pkg
module spmf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [spmf_pkg::JOB_BITS-1:0] i_job_id,
    input  logic [spmf_pkg::LEVEL_W-1:0]  i_level,
    output spmf_pkg::t_cmd                o_cmd
);
    import spmf_pkg::*;

    logic [PTR_W-1:0] r_head  [LEVELS];
    logic [PTR_W-1:0] r_tail  [LEVELS];
    logic [CNT_W-1:0] r_count [LEVELS];
    logic [PTR_W-1:0] n_head  [LEVELS];
    logic [PTR_W-1:0] n_tail  [LEVELS];
    logic [CNT_W-1:0] n_count [LEVELS];

    logic             found;
    logic [LVL_W-1:0] sel;
    logic             lvl_ok;
    logic [LVL_W-1:0] enq_idx;

    // most urgent non-empty level
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                found = 1'b1;
                sel   = LVL_W'(i);
            end
        end
    end

    assign lvl_ok  = (32'(i_level) < LEVELS);
    assign enq_idx = LVL_W'(i_level);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        o_cmd.op     = OP_NONE;
        o_cmd.addr   = '0;
        o_cmd.job    = '0;
        o_cmd.level  = '0;
        o_cmd.status = ST_OK;
        if (t_req'(i_req_type) == REQ_ENQ) begin
            if (!lvl_ok || r_count[enq_idx] == CNT_W'(DEPTH)) begin
                o_cmd.status = ST_FULL;
            end else begin
                o_cmd.op   = OP_WRITE;
                o_cmd.addr = slot_addr(enq_idx, r_tail[enq_idx]);
                o_cmd.job  = i_job_id;
                if (i_accept) begin
                    n_tail[enq_idx]  = next_ptr(r_tail[enq_idx]);
                    n_count[enq_idx] = r_count[enq_idx] + CNT_W'(1);
                end
            end
        end else begin
            if (found) begin
                o_cmd.op    = OP_READ;
                o_cmd.addr  = slot_addr(sel, r_head[sel]);
                o_cmd.level = LEVEL_W'(sel);
                if (i_accept) begin
                    n_head[sel]  = next_ptr(r_head[sel]);
                    n_count[sel] = r_count[sel] - CNT_W'(1);
                end
            end else begin
                o_cmd.status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

>>> design/spmf_cmd_q.sv
// spmf_cmd_q: short command queue that decouples the front from the back
// depends on spmf_pkg
module spmf_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spmf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spmf_pkg::t_cmd o_cmd
);
    import spmf_pkg::*;

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic [CQ_PTR_W-1:0] n_wr_ptr;
    logic [CQ_PTR_W-1:0] n_rd_ptr;
    logic [CQ_CNT_W-1:0] n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wr_ptr + CQ_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rd_ptr + CQ_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CQ_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

>>> design/spmf_back.sv
// spmf_back: job store memory, read stage and result queue
// depends on spmf_pkg
module spmf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  spmf_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [spmf_pkg::JOB_BITS-1:0] o_out_job,
    output logic [spmf_pkg::LEVEL_W-1:0]  o_out_level,
    output logic [spmf_pkg::STATUS_W-1:0] o_status
);
    import spmf_pkg::*;

    logic [JOB_BITS-1:0] r_mem [STORE_DEPTH];
    logic [JOB_BITS-1:0] r_rd_data;

    logic                r_s1_valid;
    logic                r_s1_read;
    logic [LEVEL_W-1:0]  r_s1_level;
    t_status             r_s1_status;
    t_result             s1_res;

    t_result             r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic [OQ_PTR_W-1:0] n_wr_ptr;
    logic [OQ_PTR_W-1:0] n_rd_ptr;
    logic [OQ_CNT_W-1:0] n_cnt;
    logic [OQ_CNT_W-1:0] pending;
    logic                take;
    logic                oq_pop;
    t_result             head_res;

    // room is reserved for the result still in the read stage
    assign pending   = r_cnt + OQ_CNT_W'(r_s1_valid);
    assign take      = i_cmd_valid && (pending < OQ_CNT_W'(OQ_DEPTH));
    assign o_cmd_pop = take;

    always_ff @(posedge i_clk) begin
        if (take && i_cmd.op == OP_WRITE) begin
            r_mem[i_cmd.addr] <= i_cmd.job;
        end
        if (take && i_cmd.op == OP_READ) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_read   <= (i_cmd.op == OP_READ);
            r_s1_level  <= i_cmd.level;
            r_s1_status <= i_cmd.status;
        end
    end

    always_comb begin
        s1_res.job    = r_s1_read ? r_rd_data : '0;
        s1_res.level  = r_s1_level;
        s1_res.status = r_s1_status;
    end

    assign o_empty  = (r_cnt == '0);
    assign oq_pop   = i_pop && !o_empty;
    assign head_res = r_oq[r_rd_ptr];

    assign o_out_job   = head_res.job;
    assign o_out_level = head_res.level;
    assign o_status    = head_res.status;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (r_s1_valid) begin
            n_wr_ptr = (r_wr_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wr_ptr + OQ_PTR_W'(1);
        end
        if (oq_pop) begin
            n_rd_ptr = (r_rd_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rd_ptr + OQ_PTR_W'(1);
        end
        if (r_s1_valid && !oq_pop) begin
            n_cnt = r_cnt + OQ_CNT_W'(1);
        end else if (oq_pop && !r_s1_valid) begin
            n_cnt = r_cnt - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_wr_ptr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

>>> design/strict_priority_multi_fifo.sv
// strict_priority_multi_fifo: top level of the strict priority multi-level job queue
// depends on spmf_pkg, spmf_front, spmf_cmd_q, spmf_back
//
// channel   direction  handshake            payload
// request   in         push / full          i_req_type, i_job_id, i_level
// result    out        empty / pop          o_out_job, o_out_level, o_status
//
// one request per cycle sustained while full is low; each gives exactly one result, which passes
// through the command queue, the read stage and the result queue in turn before it can be popped
// the store is a single-port memory: one write or one read per cycle
// synchronous active-low reset empties every level and both queues; store contents are not cleared
// a stalled result side fills the result queue, then the command queue, then raises full
module strict_priority_multi_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_req_type,
    input  logic [spmf_pkg::JOB_BITS-1:0] i_job_id,
    input  logic [spmf_pkg::LEVEL_W-1:0]  i_level,
    output logic                          empty,
    input  logic                          pop,
    output logic [spmf_pkg::JOB_BITS-1:0] o_out_job,
    output logic [spmf_pkg::LEVEL_W-1:0]  o_out_level,
    output logic [spmf_pkg::STATUS_W-1:0] o_status
);
    import spmf_pkg::*;

    logic accept;
    t_cmd front_cmd;
    t_cmd back_cmd;
    logic cq_full;
    logic cq_valid;
    logic cq_pop;

    assign full   = cq_full;
    assign accept = push && !cq_full;

    spmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_job_id   (i_job_id),
        .i_level    (i_level),
        .o_cmd      (front_cmd)
    );

    spmf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_valid (cq_valid),
        .o_cmd   (back_cmd)
    );

    spmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cq_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_job   (o_out_job),
        .o_out_level (o_out_level),
        .o_status    (o_status)
    );

endmodule

>>> bench/strict_priority_multi_fifo_tb.sv
// strict_priority_multi_fifo_tb: self-checking bench for the strict priority multi-level job queue
// needs spmf_pkg and strict_priority_multi_fifo; keeps its own scheduler copy to predict results
module strict_priority_multi_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spmf_pkg::*;

    localparam int                 LIMIT_CYCLES = 200000;
    localparam int                 TAIL_CYCLES  = 8;
    localparam logic [LEVEL_W-1:0] BAD_LEVEL    = LEVEL_W'(LEVELS);

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic                i_req_type;
    logic [JOB_BITS-1:0] i_job_id;
    logic [LEVEL_W-1:0]  i_level;
    logic                empty;
    logic                pop = 1'b0;
    logic [JOB_BITS-1:0] o_out_job;
    logic [LEVEL_W-1:0]  o_out_level;
    logic [STATUS_W-1:0] o_status;

    // scheduler state as seen at request acceptance
    logic [JOB_BITS-1:0] job_slots  [STORE_DEPTH];
    logic [PTR_W-1:0]    level_head [LEVELS] = '{default: '0};
    logic [PTR_W-1:0]    level_tail [LEVELS] = '{default: '0};
    logic [CNT_W-1:0]    level_fill [LEVELS] = '{default: '0};

    t_result pending_results[$];

    bit  no_idle    = 1'b0;
    bit  pop_next   = 1'b0;
    int  pop_stall  = 0;
    int  cycle_count;
    int  mismatches;
    int  requests_sent;
    int  results_checked;
    int  ok_count;
    int  empty_count;
    int  reject_count;

    strict_priority_multi_fifo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_job_id    (i_job_id),
        .i_level     (i_level),
        .empty       (empty),
        .pop         (pop),
        .o_out_job   (o_out_job),
        .o_out_level (o_out_level),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 20) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    function automatic t_result predict_request(input t_req req,
                                                input logic [JOB_BITS-1:0] job,
                                                input logic [LEVEL_W-1:0] lvl);
        t_result res;
        int      idx;
        bit      taken;
        res.job    = '0;
        res.level  = '0;
        res.status = ST_OK;
        if (req == REQ_ENQ) begin
            if (lvl >= BAD_LEVEL) begin
                res.status = ST_FULL;
            end else if (level_fill[lvl] == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
            end else begin
                idx = int'(lvl) * DEPTH + int'(level_tail[lvl]);
                job_slots[idx] = job;
                level_tail[lvl] = (level_tail[lvl] == PTR_W'(DEPTH - 1)) ? '0
                                                                   : level_tail[lvl] + PTR_W'(1);
                level_fill[lvl]++;
            end
        end else begin
            taken = 1'b0;
            // lowest-numbered non-empty level wins
            for (int l = 0; l < LEVELS; l++) begin
                if (!taken && level_fill[l] != '0) begin
                    idx = l * DEPTH + int'(level_head[l]);
                    res.job   = job_slots[idx];
                    res.level = LEVEL_W'(l);
                    level_head[l] = (level_head[l] == PTR_W'(DEPTH - 1)) ? '0
                                                                   : level_head[l] + PTR_W'(1);
                    level_fill[l]--;
                    taken = 1'b1;
                end
            end
            if (!taken) begin
                res.status = ST_EMPTY;
            end
        end
        return res;
    endfunction

    function automatic int total_jobs();
        int sum;
        sum = 0;
        for (int l = 0; l < LEVELS; l++) begin
            sum += int'(level_fill[l]);
        end
        return sum;
    endfunction

    // called and returns at a falling edge; push stays high if the next request follows at once
    task automatic send_request(input t_req req, input logic [JOB_BITS-1:0] job,
                                input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= req;
        i_job_id   <= job;
        i_level    <= lvl;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_request(req, job, lvl));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // result side: compare each accepted transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(o_out_job), 0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_job !== want.job) begin
                    report_mismatch("out_job", 32'(o_out_job), 32'(want.job));
                end
                if (o_out_level !== want.level) begin
                    report_mismatch("out_level", 32'(o_out_level), 32'(want.level));
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                case (want.status)
                    ST_OK:    ok_count++;
                    ST_EMPTY: empty_count++;
                    default:  reject_count++;
                endcase
            end
            pop_stall = no_idle ? 0 : $urandom_range(0, 9);
        end
        pop_next = (pop_stall == 0);
        if (pop_stall > 0) begin
            pop_stall--;
        end
    end

    always @(negedge i_clk) begin
        pop <= pop_next;
    end

    task automatic test_empty_dequeue();
        no_idle = 1'b0;
        send_request(REQ_DEQ, 16'hFFFF, BAD_LEVEL);
    endtask

    task automatic test_priority_order();
        no_idle = 1'b1;
        send_request(REQ_ENQ, 16'hFFFF, 2'd2);
        send_request(REQ_ENQ, 16'h0000, 2'd1);
        send_request(REQ_ENQ, 16'h8001, 2'd0);
        send_request(REQ_ENQ, 16'h7FFE, 2'd0);
        repeat (4) begin
            send_request(REQ_DEQ, 16'($urandom), 2'($urandom_range(0, 3)));
        end
        send_request(REQ_DEQ, 16'h0000, 2'd0);
    endtask

    task automatic test_invalid_level();
        no_idle = 1'b0;
        send_request(REQ_ENQ, 16'hFFFF, BAD_LEVEL);
        send_request(REQ_ENQ, 16'h5A5A, 2'd1);
        send_request(REQ_ENQ, 16'h1234, BAD_LEVEL);
        send_request(REQ_DEQ, 16'h0000, 2'd0);
        // a rejected enqueue must leave nothing behind
        send_request(REQ_DEQ, 16'h0000, 2'd0);
    endtask

    // fill every level to the brim in random order, hit full, then drain through the wrap
    task automatic test_fill_and_drain();
        logic [LEVEL_W-1:0] lvl;
        no_idle = 1'b0;
        while (total_jobs() < LEVELS * DEPTH) begin
            lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
            if ($urandom_range(0, 4) != 0) begin
                while (level_fill[lvl] == CNT_W'(DEPTH)) begin
                    lvl = (lvl == LEVEL_W'(LEVELS - 1)) ? '0 : lvl + LEVEL_W'(1);
                end
            end
            send_request(REQ_ENQ, 16'($urandom), lvl);
        end
        for (int l = 0; l < LEVELS; l++) begin
            send_request(REQ_ENQ, 16'($urandom), LEVEL_W'(l));
        end
        no_idle = 1'b1;
        while (total_jobs() != 0) begin
            send_request(REQ_DEQ, 16'($urandom), 2'($urandom_range(0, 3)));
        end
        send_request(REQ_DEQ, 16'($urandom), 2'($urandom_range(0, 3)));
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int                 enq_pct;
        int                 hot;
        int                 pick;
        t_req               req;
        logic [LEVEL_W-1:0] lvl;
        for (int p = 0; p < phases; p++) begin
            enq_pct = 15 + 14 * $urandom_range(0, 5);
            hot     = $urandom_range(0, LEVELS);
            no_idle = ($urandom_range(0, 3) == 0);
            if (p == phases / 2) begin
                wait_drained();
            end
            for (int n = 0; n < per_phase; n++) begin
                req  = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    lvl = BAD_LEVEL;
                end else if (hot < LEVELS && pick < 65) begin
                    lvl = LEVEL_W'(hot);
                end else begin
                    lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
                end
                send_request(req, 16'($urandom), lvl);
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_req_type = REQ_ENQ;
        i_job_id   = '0;
        i_level    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_dequeue();
        test_priority_order();
        test_invalid_level();
        wait_drained();
        test_fill_and_drain();
        wait_drained();
        test_random_traffic(6, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests in %0d cycles: priority order, level fill and wrap, random mixes",
                 requests_sent, cycle_count);
        $display("%0d results checked: %0d ok, %0d empty dequeues, %0d rejected enqueues",
                 results_checked, ok_count, empty_count, reject_count);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/spmf_pkg.sv
design/spmf_front.sv
design/spmf_cmd_q.sv
design/spmf_back.sv
design/strict_priority_multi_fifo.sv
bench/strict_priority_multi_fifo_tb.sv
